// File: hw/rtl/dvme_pkg.sv
// Shared types, constants and the mu-law code function of the decimating
// mu-law encoder with its energy gate. Used by every module of the block.
package dvme_pkg;

  localparam int unsigned Window   = 160;
  localparam int unsigned MaxRatio = 16;
  localparam int unsigned PosW     = $clog2(Window);
  localparam int unsigned FillW    = $clog2(Window + 1);
  localparam int unsigned CntW     = $clog2(MaxRatio + 1);
  localparam int unsigned AccW     = 16 + $clog2(MaxRatio) + 1;
  localparam int unsigned SumW     = 16 + $clog2(Window) + 1;
  localparam int unsigned StepW    = $clog2(AccW + 1);

  localparam logic [15:0] MuClip = 16'd32635;
  localparam logic [15:0] MuBias = 16'h0084;

  localparam logic [15:0] RateInRst  = 16'd44100;
  localparam logic [15:0] RateOutRst = 16'd8000;
  localparam logic [14:0] ThrRst     = 15'd300;
  localparam logic [15:0] HoldRst    = 16'd25;
  localparam logic [23:0] ChunkRst   = 24'd240000;

  typedef enum logic [2:0] {
    CFG_RATE_IN   = 3'd0,
    CFG_RATE_OUT  = 3'd1,
    CFG_VAD_EN    = 3'd2,
    CFG_VAD_THR   = 3'd3,
    CFG_VAD_HOLD  = 3'd4,
    CFG_CHUNK_LEN = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic warm;
    logic loud;
  } win_stat_t;

  function automatic logic [7:0] mu_code(input logic [15:0] s);
    logic        sign;
    logic [15:0] mag;
    logic [2:0]  expo;
    logic [3:0]  mant;
    sign = s[15];
    mag  = sign ? (16'd0 - s) : s;
    if (mag > MuClip) begin
      mag = MuClip;
    end
    mag  = mag + MuBias;
    expo = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (mag[i + 8]) begin
        expo = 3'(i + 1);
      end
    end
    mant = 4'(mag >> ({1'b0, expo} + 4'd3));
    return ~{sign, expo, mant};
  endfunction

endpackage

// File: hw/rtl/dvme_div.sv
// Restoring divider, one quotient bit per cycle, for the averaged sample.
// Depends on dvme_pkg for widths.
module dvme_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dvme_pkg::AccW-1:0]     dividend_i,
  input  logic [dvme_pkg::CntW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [dvme_pkg::AccW-1:0]     quot_o
);

  logic [dvme_pkg::AccW-1:0]  dvd_q, dvd_d;
  logic [dvme_pkg::CntW-1:0]  rem_q, rem_d, dsr_q, dsr_d;
  logic [dvme_pkg::StepW-1:0] step_q, step_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [dvme_pkg::CntW:0]    trial;
  logic [dvme_pkg::CntW:0]    shifted;

  always_comb begin
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, dvd_q[dvme_pkg::AccW-1]};
    trial   = shifted - {1'b0, dsr_q};
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[dvme_pkg::CntW]) begin
        rem_d = trial[dvme_pkg::CntW-1:0];
      end else begin
        rem_d = shifted[dvme_pkg::CntW-1:0];
      end
      dvd_d  = {dvd_q[dvme_pkg::AccW-2:0], ~trial[dvme_pkg::CntW]};
      step_d = step_q + 1'b1;
      if (step_q == dvme_pkg::StepW'(dvme_pkg::AccW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

// File: hw/rtl/dvme_win.sv
// Sliding window of absolute output levels: ring memory, fill count and sum.
// Depends on dvme_pkg for the window size and status type.
module dvme_win (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  upd_i,
  input  logic [15:0]           level_i,
  input  logic [14:0]           thr_i,
  output dvme_pkg::win_stat_t   stat_o
);

  logic [15:0]                 mem [dvme_pkg::Window];
  logic [15:0]                 rdata_q;
  logic [dvme_pkg::PosW-1:0]   pos_q, pos_d;
  logic [dvme_pkg::FillW-1:0]  fill_q, fill_d;
  logic [dvme_pkg::SumW-1:0]   sum_q, sum_d;
  logic [15:0]                 old_lvl;
  logic [dvme_pkg::SumW:0]     bound;

  always_comb begin
    old_lvl = (fill_q < dvme_pkg::FillW'(dvme_pkg::Window)) ? 16'd0 : rdata_q;
    sum_d   = sum_q - dvme_pkg::SumW'(old_lvl) + dvme_pkg::SumW'(level_i);
    pos_d   = (pos_q == dvme_pkg::PosW'(dvme_pkg::Window - 1)) ? '0 : pos_q + 1'b1;
    fill_d  = (fill_q < dvme_pkg::FillW'(dvme_pkg::Window)) ? fill_q + 1'b1 : fill_q;
    bound   = ((dvme_pkg::SumW + 1)'(thr_i) + 1'b1) *
              (dvme_pkg::SumW + 1)'(dvme_pkg::Window);
    stat_o.warm = fill_d < dvme_pkg::FillW'(dvme_pkg::Window);
    stat_o.loud = {1'b0, sum_d} >= bound;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (upd_i) begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[pos_q];
    if (upd_i) begin
      mem[pos_q] <= level_i;
    end
  end

endmodule

// File: hw/rtl/decimate_vad_mulaw_encoder_top.sv
// Top level of the decimating mu-law encoder with energy gate.
// Depends on dvme_pkg, dvme_div and dvme_win.
//
// Input samples arrive on in_valid_i / in_stall_o with pcm_in_i. Each
// transfer is accumulated and advances the phase. A sample that completes
// no output is accepted without a stall, so such samples can follow back to
// back. A sample that completes an output stalls the input while the
// bit-serial divider runs (one bit per cycle over the accumulator width),
// while its done flag is registered and through the update state.
// Results leave on out_valid_o / out_stall_i through an output register:
// pcm_out_o, mulaw_code_o, kept_o, chunk_end_o and chunk_bytes_o. While the
// receiver stalls, the result holds and a following output waits in its
// update cycle, with the input stalled, until the register is free.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i
// while the block is idle. Reset restores the default registers, clears the
// phase, accumulator, window, holdover and chunk counters and empties the
// output register; no clearing pass is needed.
module decimate_vad_mulaw_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pcm_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pcm_out_o,
  output logic [7:0]  mulaw_code_o,
  output logic        kept_o,
  output logic        chunk_end_o,
  output logic [23:0] chunk_bytes_o
);

  logic [15:0] rate_in_q, rate_out_q, hold_cfg_q;
  logic [14:0] thr_q;
  logic        vad_en_q;
  logic [23:0] chunk_len_q;

  dvme_pkg::state_e state_q, state_d;

  logic [16:0]                  phase_q, phase_d;
  logic [dvme_pkg::AccW-1:0]    acc_q, acc_d;
  logic [dvme_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                         neg_q, neg_d;
  logic [15:0]                  hold_q, hold_d;
  logic [23:0]                  csmp_q, csmp_d, ckept_q, ckept_d;

  logic        out_valid_q, out_valid_d;
  logic [15:0] pcm_q, pcm_d;
  logic [7:0]  code_q, code_d;
  logic        kept_q, kept_d, end_q, end_d;
  logic [23:0] bytes_q, bytes_d;

  logic                         div_start, div_done, win_upd;
  logic [dvme_pkg::AccW-1:0]    div_dvd, div_quot;
  logic [dvme_pkg::AccW-1:0]    sum_new;
  logic [dvme_pkg::CntW-1:0]    cnt_new;
  logic [16:0]                  modulus, incr, ph_sum;
  logic [23:0]                  limit, csmp_inc;
  logic [15:0]                  avg, level;
  logic                         in_xfer, out_free, keep;
  dvme_pkg::win_stat_t          wstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_in_q   <= dvme_pkg::RateInRst;
      rate_out_q  <= dvme_pkg::RateOutRst;
      vad_en_q    <= 1'b1;
      thr_q       <= dvme_pkg::ThrRst;
      hold_cfg_q  <= dvme_pkg::HoldRst;
      chunk_len_q <= dvme_pkg::ChunkRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dvme_pkg::CFG_RATE_IN:   rate_in_q   <= cfg_wdata_i[15:0];
        dvme_pkg::CFG_RATE_OUT:  rate_out_q  <= cfg_wdata_i[15:0];
        dvme_pkg::CFG_VAD_EN:    vad_en_q    <= cfg_wdata_i[0];
        dvme_pkg::CFG_VAD_THR:   thr_q       <= cfg_wdata_i[14:0];
        dvme_pkg::CFG_VAD_HOLD:  hold_cfg_q  <= cfg_wdata_i[15:0];
        dvme_pkg::CFG_CHUNK_LEN: chunk_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != dvme_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    modulus  = (rate_in_q == 16'd0) ? 17'd1 : {1'b0, rate_in_q};
    incr     = ({1'b0, rate_out_q} < modulus) ? {1'b0, rate_out_q} : modulus;
    ph_sum   = phase_q + incr;
    sum_new  = acc_q + dvme_pkg::AccW'(signed'(pcm_in_i));
    cnt_new  = cnt_q + 1'b1;
    div_dvd  = sum_new[dvme_pkg::AccW-1] ? (dvme_pkg::AccW'(0) - sum_new) : sum_new;
    limit    = (chunk_len_q == 24'd0) ? 24'd1 : chunk_len_q;
    csmp_inc = csmp_q + 1'b1;
    avg      = neg_q ? (16'd0 - div_quot[15:0]) : div_quot[15:0];
    level    = div_quot[15:0];

    state_d     = state_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    hold_d      = hold_q;
    csmp_d      = csmp_q;
    ckept_d     = ckept_q;
    out_valid_d = out_valid_q && out_stall_i;
    pcm_d       = pcm_q;
    code_d      = code_q;
    kept_d      = kept_q;
    end_d       = end_q;
    bytes_d     = bytes_q;
    div_start   = 1'b0;
    win_upd     = 1'b0;
    keep        = 1'b1;

    unique case (state_q)
      dvme_pkg::ST_IDLE: begin
        if (in_xfer) begin
          phase_d = (ph_sum >= modulus) ? ph_sum - modulus : ph_sum;
          if ((ph_sum >= modulus) ||
              (cnt_new >= dvme_pkg::CntW'(dvme_pkg::MaxRatio))) begin
            div_start = 1'b1;
            neg_d     = sum_new[dvme_pkg::AccW-1];
            acc_d     = '0;
            cnt_d     = '0;
            state_d   = dvme_pkg::ST_DIV;
          end else begin
            acc_d = sum_new;
            cnt_d = cnt_new;
          end
        end
      end
      dvme_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = dvme_pkg::ST_UPD;
        end
      end
      dvme_pkg::ST_UPD: begin
        if (!vad_en_q || wstat.warm) begin
          keep = 1'b1;
        end else if (wstat.loud) begin
          hold_d = hold_cfg_q;
        end else if (hold_q != 16'd0) begin
          hold_d = hold_q - 1'b1;
        end else begin
          keep = 1'b0;
        end
        if (out_free) begin
          win_upd     = 1'b1;
          out_valid_d = 1'b1;
          pcm_d       = avg;
          code_d      = dvme_pkg::mu_code(avg);
          kept_d      = keep;
          ckept_d     = ckept_q + 24'(keep);
          if (csmp_inc >= limit) begin
            end_d   = 1'b1;
            bytes_d = ckept_q + 24'(keep);
            csmp_d  = '0;
            ckept_d = '0;
          end else begin
            end_d   = 1'b0;
            bytes_d = '0;
            csmp_d  = csmp_inc;
          end
          state_d = dvme_pkg::ST_IDLE;
        end else begin
          hold_d = hold_q;
        end
      end
      default: state_d = dvme_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dvme_pkg::ST_IDLE;
      phase_q     <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      hold_q      <= '0;
      csmp_q      <= '0;
      ckept_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      hold_q      <= hold_d;
      csmp_q      <= csmp_d;
      ckept_q     <= ckept_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    pcm_q   <= pcm_d;
    code_q  <= code_d;
    kept_q  <= kept_d;
    end_q   <= end_d;
    bytes_q <= bytes_d;
  end

  dvme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cnt_new),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  dvme_win u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (win_upd),
    .level_i (level),
    .thr_i   (thr_q),
    .stat_o  (wstat)
  );

  assign out_valid_o   = out_valid_q;
  assign pcm_out_o     = pcm_q;
  assign mulaw_code_o  = code_q;
  assign kept_o        = kept_q;
  assign chunk_end_o   = end_q;
  assign chunk_bytes_o = bytes_q;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == dvme_pkg::ST_DIV)
    else $error("divider finished outside the divide phase");

  a_bytes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chunk_end_o |-> chunk_bytes_o == 24'd0)
    else $error("kept-byte count given without a chunk end");

  a_gate_off_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !vad_en_q |-> kept_o)
    else $error("sample dropped with the gate disabled");

  a_upd_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_upd |=> out_valid_o && state_q == dvme_pkg::ST_IDLE)
    else $error("window update without a result in the output register");
`endif

endmodule
